// ----- design/stt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types, codes and helpers for the script text tokenizer
// Transfer payloads, scan modes, token kinds and the single-character test.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Character codes the scanner reacts to
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Configuration register indexes and reset values
    localparam int          CFG_ADDR_W      = 1;
    localparam int          CFG_DATA_W      = 64;
    localparam logic [CFG_ADDR_W-1:0] CFG_SINGLE_LOW  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SINGLE_HIGH = 1'd1;
    localparam logic [CFG_DATA_W-1:0] RST_SINGLE_LOW  = 64'd21440476741632;
    localparam logic [CFG_DATA_W-1:0] RST_SINGLE_HIGH = 64'd2882303761517117440;

    // Result slots per input byte and output queue depth
    localparam int QUEUE_DEPTH = 3;

    typedef enum logic [2:0] {
        MODE_BETWEEN  = 3'd0,
        MODE_SLASH    = 3'd1,
        MODE_COMMENT  = 3'd2,
        MODE_STR_OPEN = 3'd3,
        MODE_STRING   = 3'd4,
        MODE_WORD     = 3'd5
    } t_scan_mode;

    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_STRING = 2'd1,
        KIND_SINGLE = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       token_start;
        logic       token_end;
        logic [1:0] token_kind;
        logic       empty_token;
        logic       run_last;
    } t_out_item;

    // Results of one input byte, pushed into the output queue together
    typedef struct packed {
        logic [1:0]      count;
        t_out_item [2:0] items;
    } t_push;

    // Byte belongs to the configured single-character set
    function automatic logic is_single(input logic [7:0] b,
                                       input logic [CFG_DATA_W-1:0] set_low,
                                       input logic [CFG_DATA_W-1:0] set_high);
        logic r;
        if (b[7]) begin
            r = 1'b0;
        end else if (b[6]) begin
            r = set_high[b[5:0]];
        end else begin
            r = set_low[b[5:0]];
        end
        return r;
    endfunction

endpackage

// ----- design/stt_lex.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_lex: input register, scan state and per-byte token decode
// Registers one text byte, decodes up to two results from it in one pass
// and commits the scan state when the output queue has room for them.
// ----------------------------------------------------------------------------
module stt_lex
    import stt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_data,
    input  logic [CFG_DATA_W-1:0] i_single_low,
    input  logic [CFG_DATA_W-1:0] i_single_high,
    input  logic [1:0]            i_space,
    output t_push                 o_push
);

    logic       r_in_valid;
    t_in_item   r_in;
    t_scan_mode r_mode, n_mode, m_mode;
    logic [7:0] r_held_byte, n_held_byte, m_held_byte;
    logic       r_held_valid, n_held_valid, m_held_valid;
    logic       r_held_first, n_held_first, m_held_first;

    logic [7:0] b;
    logic       eot;
    logic       b_single, slash_single, b_ws, b_break;
    logic       run_begin;
    t_out_item  s0, s1, s2;
    logic       v0, v1, v2;
    t_out_item  [2:0] items;
    logic [1:0] n_res;
    logic       commit;

    assign b            = r_in.in_byte;
    assign eot          = r_in.end_of_text;
    assign b_single     = is_single(b, i_single_low, i_single_high);
    assign slash_single = is_single(CH_SLASH, i_single_low, i_single_high);
    assign b_ws         = (b <= CH_SPACE);
    assign b_break      = b_ws || b_single;

    // Commit when every result of the byte fits in the queue
    assign commit  = r_in_valid && (n_res <= i_space);
    assign o_ready = !r_in_valid || commit;

    // Hold the incoming byte until it is committed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_BETWEEN;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
        end else if (commit) begin
            r_mode       <= n_mode;
            r_held_valid <= n_held_valid;
            r_held_first <= n_held_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte <= 8'd0;
        end else if (commit) begin
            r_held_byte <= n_held_byte;
        end
    end

    // Next state: mode step, then token start, then end-of-text flush
    always_comb begin
        run_begin    = 1'b0;
        m_mode       = r_mode;
        m_held_byte  = r_held_byte;
        m_held_valid = r_held_valid;
        m_held_first = r_held_first;
        unique case (r_mode)
            MODE_SLASH: begin
                if (b == CH_SLASH) begin
                    m_mode = MODE_COMMENT;
                end else if (slash_single || b_break) begin
                    run_begin = 1'b1;
                end else begin
                    m_held_byte  = b;
                    m_held_valid = 1'b1;
                    m_held_first = 1'b0;
                    m_mode       = MODE_WORD;
                end
            end
            MODE_COMMENT: begin
                if (b == CH_NEWLINE) begin
                    m_mode = MODE_BETWEEN;
                end
            end
            MODE_STR_OPEN: begin
                if (b == CH_QUOTE) begin
                    m_mode = MODE_BETWEEN;
                end else begin
                    m_held_byte  = b;
                    m_held_valid = 1'b1;
                    m_held_first = 1'b1;
                    m_mode       = MODE_STRING;
                end
            end
            MODE_STRING: begin
                if (b == CH_QUOTE) begin
                    m_mode       = MODE_BETWEEN;
                    m_held_valid = 1'b0;
                    m_held_first = 1'b0;
                end else begin
                    m_held_byte  = b;
                    m_held_valid = 1'b1;
                    m_held_first = 1'b0;
                end
            end
            MODE_WORD: begin
                if (b_break) begin
                    run_begin = 1'b1;
                end else begin
                    m_held_byte  = b;
                    m_held_valid = 1'b1;
                    m_held_first = 1'b0;
                end
            end
            default: begin
                run_begin = 1'b1;
            end
        endcase

        // Token start from between tokens
        if (run_begin) begin
            m_mode       = MODE_BETWEEN;
            m_held_valid = 1'b0;
            m_held_first = 1'b0;
            if (b_ws) begin
                m_mode = MODE_BETWEEN;
            end else if (b == CH_SLASH) begin
                m_mode = MODE_SLASH;
            end else if (b == CH_QUOTE) begin
                m_mode = MODE_STR_OPEN;
            end else if (!b_single) begin
                m_held_byte  = b;
                m_held_valid = 1'b1;
                m_held_first = 1'b1;
                m_mode       = MODE_WORD;
            end
        end

        // Flush returns to between tokens
        if (eot) begin
            n_mode       = MODE_BETWEEN;
            n_held_byte  = 8'd0;
            n_held_valid = 1'b0;
            n_held_first = 1'b0;
        end else begin
            n_mode       = m_mode;
            n_held_byte  = m_held_byte;
            n_held_valid = m_held_valid;
            n_held_first = m_held_first;
        end
    end

    // Results: one from the mode step, one from a token start, one from flush
    always_comb begin
        s0 = '0;
        s1 = '0;
        s2 = '0;
        v0 = 1'b0;
        v1 = 1'b0;
        v2 = 1'b0;
        unique case (r_mode)
            MODE_SLASH: begin
                if (b != CH_SLASH) begin
                    v0             = 1'b1;
                    s0.out_byte    = CH_SLASH;
                    s0.token_start = 1'b1;
                    s0.token_end   = slash_single || b_break;
                    s0.token_kind  = slash_single ? KIND_SINGLE : KIND_WORD;
                end
            end
            MODE_STR_OPEN: begin
                if (b == CH_QUOTE) begin
                    v0             = 1'b1;
                    s0.token_start = 1'b1;
                    s0.token_end   = 1'b1;
                    s0.token_kind  = KIND_STRING;
                    s0.empty_token = 1'b1;
                end
            end
            MODE_STRING: begin
                v0             = 1'b1;
                s0.out_byte    = r_held_byte;
                s0.token_start = r_held_first;
                s0.token_end   = (b == CH_QUOTE);
                s0.token_kind  = KIND_STRING;
            end
            MODE_WORD: begin
                v0             = 1'b1;
                s0.out_byte    = r_held_byte;
                s0.token_start = r_held_first;
                s0.token_end   = b_break;
                s0.token_kind  = KIND_WORD;
            end
            default: begin
                v0 = 1'b0;
            end
        endcase

        // Single-character token at a token start
        if (run_begin && !b_ws && (b != CH_SLASH) && (b != CH_QUOTE) && b_single) begin
            v1             = 1'b1;
            s1.out_byte    = b;
            s1.token_start = 1'b1;
            s1.token_end   = 1'b1;
            s1.token_kind  = KIND_SINGLE;
        end

        // End of text: give out whatever is pending
        if (eot) begin
            unique case (m_mode)
                MODE_SLASH: begin
                    v2             = 1'b1;
                    s2.out_byte    = CH_SLASH;
                    s2.token_start = 1'b1;
                    s2.token_end   = 1'b1;
                    s2.token_kind  = slash_single ? KIND_SINGLE : KIND_WORD;
                end
                MODE_STR_OPEN: begin
                    v2             = 1'b1;
                    s2.token_start = 1'b1;
                    s2.token_end   = 1'b1;
                    s2.token_kind  = KIND_STRING;
                    s2.empty_token = 1'b1;
                end
                MODE_STRING, MODE_WORD: begin
                    v2             = m_held_valid;
                    s2.out_byte    = m_held_byte;
                    s2.token_start = m_held_first;
                    s2.token_end   = 1'b1;
                    s2.token_kind  = (m_mode == MODE_STRING) ? KIND_STRING : KIND_WORD;
                end
                default: begin
                    v2 = 1'b0;
                end
            endcase
        end
    end

    // Pack the valid results in order and mark the last one
    always_comb begin
        items = '0;
        n_res = 2'd0;
        if (v0) begin
            items[n_res] = s0;
            n_res        = n_res + 2'd1;
        end
        if (v1) begin
            items[n_res] = s1;
            n_res        = n_res + 2'd1;
        end
        if (v2) begin
            items[n_res] = s2;
            n_res        = n_res + 2'd1;
        end
        if (n_res != 2'd0) begin
            items[n_res - 2'd1].run_last = 1'b1;
        end
    end

    assign o_push.count = commit ? n_res : 2'd0;
    assign o_push.items = items;

`ifndef SYNTH
    // A held byte exists only inside a word or a string
    a_held_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_mode == MODE_STRING || r_mode == MODE_WORD))
        else $error("held byte outside word or string");

    // End of text leaves the scanner between tokens
    a_eot_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && eot) |=> (r_mode == MODE_BETWEEN && !r_held_valid))
        else $error("scan state not cleared after end of text");

    // Never push more results than the queue can hold
    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count <= i_space)
        else $error("push exceeds queue space");
`endif

endmodule

// ----- design/stt_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_outq: three-entry result queue
// Takes up to three results of one byte at once and hands them out one per
// transfer on the output channel.
// ----------------------------------------------------------------------------
module stt_outq
    import stt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic [1:0] o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_out_item  r_q [QUEUE_DEPTH];
    t_out_item  n_q [QUEUE_DEPTH];
    t_out_item  sh  [QUEUE_DEPTH];
    logic [1:0] r_count, n_count;
    logic [1:0] base;
    logic [1:0] k;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q[0];
    assign o_space = 2'(QUEUE_DEPTH) - r_count;
    assign pop     = o_valid && i_ready;
    assign base    = r_count - {1'b0, pop};
    assign n_count = base + i_push.count;

    // Advance on a transfer, then append the pushed results behind
    always_comb begin
        sh[0] = pop ? r_q[1] : r_q[0];
        sh[1] = pop ? r_q[2] : r_q[1];
        sh[2] = r_q[2];
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            k      = 2'(j) - base;
            n_q[j] = sh[j];
            if ((2'(j) >= base) && (k < i_push.count)) begin
                n_q[j] = i_push.items[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

`ifndef SYNTH
    // Fill level follows pushes and transfers
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count - {1'b0, pop} + i_push.count)))
        else $error("queue count mismatch");

    // The last pushed result of a byte carries the run marker
    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> i_push.items[i_push.count - 2'd1].run_last)
        else $error("pushed results lack run marker");

    // A push never overruns the queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count <= o_space)
        else $error("queue overrun");
`endif

endmodule

// ----- design/script_text_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_text_tokenizer: streaming script text lexer
// Splits a byte stream into word, quoted-string and single-character tokens
// with start and end marks; holds the single-character set registers.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------
//   text in  | in        | i_valid / o_ready   | i_data  (t_in_item)
//   tokens   | out       | o_valid / i_ready   | o_data  (t_out_item)
//   config   | in        | i_cfg_we            | i_cfg_addr, i_cfg_wdata
//
// One byte per cycle while the result queue has room; the first result of a byte
// passes the input register, then the result queue, on its way out.
// A byte is committed only when the three-entry result queue has room for all
// of its results (at most two); a two-result byte can hold the input even with
// the output never stalled, and output stalls hold it longer.
// Synchronous active-low reset clears scan state and queue, and loads the
// default single-character set; no clearing pass.
// ----------------------------------------------------------------------------
module script_text_tokenizer
    import stt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [CFG_DATA_W-1:0] r_single_low;
    logic [CFG_DATA_W-1:0] r_single_high;
    logic [1:0]            space;
    t_push                 push;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single_low  <= RST_SINGLE_LOW;
            r_single_high <= RST_SINGLE_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SINGLE_LOW:  r_single_low  <= i_cfg_wdata;
                CFG_SINGLE_HIGH: r_single_high <= i_cfg_wdata;
                default: begin
                    r_single_low <= r_single_low;
                end
            endcase
        end
    end

    stt_lex u_lex (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_data),
        .i_single_low  (r_single_low),
        .i_single_high (r_single_high),
        .i_space       (space),
        .o_push        (push)
    );

    stt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ----- tb/tb_script_text_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_script_text_tokenizer: self-checking bench for the script text lexer
// Streams text bytes through the valid/ready input, predicts every token byte
// with a cycle-free lexer model kept in step at each input transfer, and
// compares each output transfer with the oldest prediction. Covers directed
// corner cases under two single-character sets, then random well-formed text
// with noise under several sets and three patterns of sender/receiver stalls.
// ----------------------------------------------------------------------------
module tb_script_text_tokenizer;
    import stt_pkg::*;

    localparam int  MAX_SHOWN = 10;
    localparam int  SETTLE_CYCLES = 6;
    localparam time RUN_LIMIT = 2_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in_item              i_data;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_out_item             o_data;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Lexer prediction state
    t_scan_mode            lex_mode;
    logic [7:0]            held_chr;
    logic                  held_live;
    logic                  held_first;
    logic [CFG_DATA_W-1:0] set_low;
    logic [CFG_DATA_W-1:0] set_high;

    t_out_item             step_tokens[$];
    t_out_item             tok_expect[$];
    t_out_item             tok_want;
    int                    err_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;

    script_text_tokenizer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer prediction
    // ------------------------------------------------------------------

    // Byte codes below 128 may be configured as one-character tokens
    function automatic logic single_chr(input logic [7:0] b);
        logic [127:0] both;
        both = {set_high, set_low};
        return (b < 8'd128) && both[b[6:0]];
    endfunction

    function automatic void emit_tok(input logic [7:0] b, input logic first,
                                     input logic last, input t_kind kind,
                                     input logic empty);
        t_out_item r;
        r.out_byte    = b;
        r.token_start = first;
        r.token_end   = last;
        r.token_kind  = kind;
        r.empty_token = empty;
        r.run_last    = 1'b0;
        step_tokens.push_back(r);
    endfunction

    function automatic void keep_byte(input logic [7:0] b, input logic first,
                                      input t_scan_mode mode);
        held_chr   = b;
        held_live  = 1'b1;
        held_first = first;
        lex_mode   = mode;
    endfunction

    function automatic void drop_held();
        held_live  = 1'b0;
        held_first = 1'b0;
    endfunction

    // Byte seen between tokens
    function automatic void start_token(input logic [7:0] b);
        lex_mode = MODE_BETWEEN;
        drop_held();
        if (b > CH_SPACE) begin
            if (b == CH_SLASH) begin
                lex_mode = MODE_SLASH;
            end else if (b == CH_QUOTE) begin
                lex_mode = MODE_STR_OPEN;
            end else if (single_chr(b)) begin
                emit_tok(b, 1'b1, 1'b1, KIND_SINGLE, 1'b0);
            end else begin
                keep_byte(b, 1'b1, MODE_WORD);
            end
        end
    endfunction

    // Byte seen while a word byte is held
    function automatic void word_step(input logic [7:0] b);
        if (b <= CH_SPACE || single_chr(b)) begin
            emit_tok(held_chr, held_first, 1'b1, KIND_WORD, 1'b0);
            start_token(b);
        end else begin
            emit_tok(held_chr, held_first, 1'b0, KIND_WORD, 1'b0);
            keep_byte(b, 1'b0, MODE_WORD);
        end
    endfunction

    // Close whatever is open at the end of the text
    function automatic void flush_text();
        case (lex_mode)
            MODE_SLASH: begin
                emit_tok(CH_SLASH, 1'b1, 1'b1,
                         single_chr(CH_SLASH) ? KIND_SINGLE : KIND_WORD, 1'b0);
            end
            MODE_STR_OPEN: begin
                emit_tok(8'h00, 1'b1, 1'b1, KIND_STRING, 1'b1);
            end
            MODE_STRING, MODE_WORD: begin
                if (held_live) begin
                    emit_tok(held_chr, held_first, 1'b1,
                             lex_mode == MODE_STRING ? KIND_STRING : KIND_WORD, 1'b0);
                end
            end
            default: begin
            end
        endcase
        lex_mode = MODE_BETWEEN;
        held_chr = 8'h00;
        drop_held();
    endfunction

    // Advance the lexer by one text byte and queue the token bytes it gives
    function automatic void lex_byte(input logic [7:0] b, input logic eot);
        step_tokens.delete();
        case (lex_mode)
            MODE_SLASH: begin
                if (b == CH_SLASH) begin
                    lex_mode = MODE_COMMENT;
                end else if (single_chr(CH_SLASH)) begin
                    emit_tok(CH_SLASH, 1'b1, 1'b1, KIND_SINGLE, 1'b0);
                    start_token(b);
                end else begin
                    keep_byte(CH_SLASH, 1'b1, MODE_WORD);
                    word_step(b);
                end
            end
            MODE_COMMENT: begin
                if (b == CH_NEWLINE) lex_mode = MODE_BETWEEN;
            end
            MODE_STR_OPEN: begin
                if (b == CH_QUOTE) begin
                    emit_tok(8'h00, 1'b1, 1'b1, KIND_STRING, 1'b1);
                    lex_mode = MODE_BETWEEN;
                end else begin
                    keep_byte(b, 1'b1, MODE_STRING);
                end
            end
            MODE_STRING: begin
                if (b == CH_QUOTE) begin
                    emit_tok(held_chr, held_first, 1'b1, KIND_STRING, 1'b0);
                    lex_mode = MODE_BETWEEN;
                    drop_held();
                end else begin
                    emit_tok(held_chr, held_first, 1'b0, KIND_STRING, 1'b0);
                    keep_byte(b, 1'b0, MODE_STRING);
                end
            end
            MODE_WORD: word_step(b);
            default:   start_token(b);
        endcase
        if (eot) flush_text();
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].run_last = 1'b1;
        foreach (step_tokens[i]) tok_expect.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one text byte; returns at the falling edge after the transfer
    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            i_data  = t_in_item'($urandom);
            @(negedge i_clk);
        end
        i_valid             = 1'b1;
        i_data.in_byte      = b;
        i_data.end_of_text  = eot;
        do @(posedge i_clk); while (!o_ready);
        lex_byte(b, eot);
        @(negedge i_clk);
    endtask

    // Hold off until every predicted token byte has arrived and the pipe is quiet
    task automatic wait_drain();
        i_valid = 1'b0;
        while (tok_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        if (addr == CFG_SINGLE_LOW) set_low = data;
        else set_high = data;
    endtask

    task automatic load_singles(input logic [CFG_DATA_W-1:0] low_bits,
                                input logic [CFG_DATA_W-1:0] high_bits);
        wait_drain();
        write_reg(CFG_SINGLE_LOW, low_bits);
        write_reg(CFG_SINGLE_HIGH, high_bits);
    endtask

    // Random text: mostly well-formed words, strings, comments and singles
    task automatic send_random_text(input int n_bytes);
        logic [7:0] piece[$];
        logic [7:0] b;
        int         sent;
        int         len;
        sent = 0;
        while (sent < n_bytes) begin
            piece.delete();
            len = $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    piece.push_back(8'($urandom_range(8'h21, 8'hFF)));
                    repeat (len) piece.push_back(8'($urandom_range(8'h21, 8'hFF)));
                end
                3, 4: begin
                    piece.push_back(CH_QUOTE);
                    repeat (len) begin
                        b = 8'($urandom_range(0, 255));
                        piece.push_back(b == CH_QUOTE ? 8'h51 : b);
                    end
                    piece.push_back(CH_QUOTE);
                end
                5: begin
                    piece.push_back(CH_SLASH);
                    piece.push_back(CH_SLASH);
                    repeat (len) begin
                        b = 8'($urandom_range(0, 255));
                        piece.push_back(b == CH_NEWLINE ? 8'h2A : b);
                    end
                    piece.push_back(CH_NEWLINE);
                end
                6:       piece.push_back(8'($urandom_range(8'h21, 8'h7F)));
                7:       piece.push_back(8'($urandom_range(0, CH_SPACE)));
                default: piece.push_back(8'($urandom_range(0, 255)));
            endcase
            foreach (piece[i]) send_text_byte(piece[i], $urandom_range(0, 39) == 0);
            sent += piece.size();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void note_mismatch(input string what, input t_out_item want,
                                          input t_out_item got);
        err_count++;
        if (err_count <= MAX_SHOWN) begin
            $display("%0t %s: want byte %02h start %0b end %0b kind %0d empty %0b last %0b",
                     $realtime, what, want.out_byte, want.token_start, want.token_end,
                     want.token_kind, want.empty_token, want.run_last);
            $display("    got byte %02h start %0b end %0b kind %0d empty %0b last %0b",
                     got.out_byte, got.token_start, got.token_end,
                     got.token_kind, got.empty_token, got.run_last);
        end
    endfunction

    // Compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (tok_expect.size() == 0) begin
                note_mismatch("unexpected token byte", '0, o_data);
            end else begin
                tok_want = tok_expect.pop_front();
                if (o_data.out_byte !== tok_want.out_byte
                        || o_data.token_start !== tok_want.token_start
                        || o_data.token_end !== tok_want.token_end
                        || o_data.token_kind !== tok_want.token_kind
                        || o_data.empty_token !== tok_want.empty_token
                        || o_data.run_last !== tok_want.run_last) begin
                    note_mismatch("token byte mismatch", tok_want, o_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset set: words with slash, quote and high bytes, comments, strings, text end
    task automatic test_directed_reset_set();
        send_text_byte(8'h61, 1'b0);
        send_text_byte(CH_SLASH, 1'b0);
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h80, 1'b0);
        send_text_byte(8'h28, 1'b0);
        // lone slash starts a word, ended by a zero byte
        send_text_byte(CH_SLASH, 1'b0);
        send_text_byte(8'h7F, 1'b0);
        send_text_byte(8'h00, 1'b0);
        // comment up to the newline
        send_text_byte(CH_SLASH, 1'b0);
        send_text_byte(CH_SLASH, 1'b0);
        send_text_byte(8'h7A, 1'b0);
        send_text_byte(CH_NEWLINE, 1'b0);
        // empty string, then a one-byte string
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(8'h71, 1'b0);
        send_text_byte(CH_QUOTE, 1'b0);
        // end of text in each open state
        send_text_byte(8'h77, 1'b1);
        send_text_byte(CH_QUOTE, 1'b1);
        send_text_byte(CH_SLASH, 1'b1);
        send_text_byte(CH_SLASH, 1'b0);
        send_text_byte(CH_SLASH, 1'b1);
    endtask

    // Every low code single: slash, space and quote keep their special roles
    task automatic test_directed_full_set();
        load_singles('1, '1);
        send_text_byte(CH_SLASH, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(CH_SPACE, 1'b0);
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(8'h78, 1'b0);
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(8'hC3, 1'b0);
        send_text_byte(CH_QUOTE, 1'b1);
    endtask

    task automatic test_random_mixed_set();
        load_singles({$urandom, $urandom}, {$urandom, $urandom});
        send_random_text(22);
    endtask

    task automatic test_random_empty_set();
        load_singles('0, '0);
        send_random_text(22);
    endtask

    task automatic test_random_reset_set();
        load_singles(RST_SINGLE_LOW, RST_SINGLE_HIGH);
        send_random_text(22);
    endtask

    // Guard against a hung handshake
    initial begin
        #RUN_LIMIT;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        lex_mode    = MODE_BETWEEN;
        held_chr    = 8'h00;
        held_live   = 1'b0;
        held_first  = 1'b0;
        set_low     = RST_SINGLE_LOW;
        set_high    = RST_SINGLE_HIGH;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 80;
        test_directed_reset_set();
        test_directed_full_set();
        test_random_mixed_set();

        send_idle_pct = 80;
        recv_idle_pct = 38;
        test_random_empty_set();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_reset_set();

        wait_drain();
        if (tok_expect.size() != 0) err_count += tok_expect.size();
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
